// File: rtl/ierl_pkg.sv
// Package with the codes, state type and record types of the interval event ring log.
package ierl_pkg;

  // Event codes carried in the mode field of a request.
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_END   = 2'd1;
  localparam logic [1:0] MODE_POINT = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  // Status codes returned with every result.
  localparam logic [2:0] STAT_STARTED      = 3'd0;
  localparam logic [2:0] STAT_ALREADY_OPEN = 3'd1;
  localparam logic [2:0] STAT_ENDED        = 3'd2;
  localparam logic [2:0] STAT_NONE_OPEN    = 3'd3;
  localparam logic [2:0] STAT_POINT        = 3'd4;
  localparam logic [2:0] STAT_READ_OK      = 3'd5;
  localparam logic [2:0] STAT_READ_BAD     = 3'd6;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EVAL,
    ST_RDATA,
    ST_OUT
  } ierl_state_t;

  // Fixed part of a record; the end time lives in a memory of its own.
  typedef struct packed {
    logic [7:0]  reason;
    logic [7:0]  detail;
    logic [31:0] start;
  } ierl_meta_t;

  // One result as it waits in the output register.
  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  entry_count;
    logic        any_open;
    logic [7:0]  newest_reason;
    logic [7:0]  entry_reason;
    logic [7:0]  entry_detail;
    logic [31:0] entry_start;
    logic [31:0] entry_end;
  } ierl_result_t;

endpackage

// File: rtl/ierl_req_if.sv
// Request channel interface of the interval event ring log.
interface ierl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  reason;
  logic [7:0]  detail;
  logic [31:0] timestamp;
  logic [4:0]  read_position;

  modport source (output valid, mode, reason, detail, timestamp, read_position, input ready);
  modport sink (input valid, mode, reason, detail, timestamp, read_position, output ready);
endinterface

// File: rtl/ierl_rsp_if.sv
// Result channel interface of the interval event ring log.
interface ierl_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [4:0]  entry_count;
  logic        any_open;
  logic [7:0]  newest_reason;
  logic [7:0]  entry_reason;
  logic [7:0]  entry_detail;
  logic [31:0] entry_start;
  logic [31:0] entry_end;

  modport source (output valid, status, entry_count, any_open, newest_reason, entry_reason,
                  entry_detail, entry_start, entry_end, input ready);
  modport sink (input valid, status, entry_count, any_open, newest_reason, entry_reason,
                entry_detail, entry_start, entry_end, output ready);
endinterface

// File: rtl/interval_event_ring_log.sv
// Interval event ring log: a ring of interval records kept in two memories with registered reads.
// Sequence: SCAN reads one valid slot a cycle (skipped on an empty log), DRAIN takes the last
// read, EVAL decides and writes, RDATA fetches the entry for a read that hits, and OUT waits
// for a free output register. Throughput: one event at a time; the next request is taken
// as soon as the result is in the output register.
// Reset: synchronous; clears the count, write pointer, newest kind and handshake state.
// The record memories are not cleared, since only written slots are ever read.
module interval_event_ring_log
  import ierl_pkg::*;
#(
  parameter int RING_DEPTH = 20
) (
  input  logic       clk,
  input  logic       rst,
  ierl_req_if.sink   req,
  ierl_rsp_if.source rsp
);

  localparam int IDX_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  localparam logic [IDX_W-1:0] PTR_WRAP = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

  // Record memories.
  ierl_meta_t  meta_mem [RING_DEPTH];
  logic [31:0] end_mem  [RING_DEPTH];

  ierl_state_t state, state_next;

  // Ring bookkeeping.
  logic [CNT_W-1:0] valid_count;
  logic [IDX_W-1:0] write_pointer;
  logic [7:0]       newest_reason;

  // Latched request.
  logic [1:0]  q_mode;
  logic [7:0]  q_reason;
  logic [7:0]  q_detail;
  logic [31:0] q_ts;
  logic [4:0]  q_pos;

  // Scan state.
  logic [IDX_W-1:0] scan_idx;
  logic             pend;
  logic [IDX_W-1:0] pend_idx;
  logic             found;
  logic [IDX_W-1:0] match_idx;
  logic [1:0]       open_cnt;
  logic             open_excl;

  // Memory ports.
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  ierl_meta_t       rd_meta;
  logic [31:0]      rd_end;
  logic             meta_we;
  logic             end_we;
  logic [IDX_W-1:0] end_waddr;
  logic [31:0]      end_wdata;

  // Control outputs of the sequencer.
  logic scan_last;
  logic out_free;
  logic out_load;

  // Evaluation results.
  logic             do_append;
  logic             do_close;
  logic             rd_ok;
  logic [2:0]       ev_status;
  logic             ev_any;
  logic [IDX_W-1:0] slot_sel;
  logic [CNT_W-1:0] count_after;
  logic [CMP_W:0]   sum_pos;
  logic [CMP_W:0]   sum_wrap;
  logic [IDX_W-1:0] first_slot;
  logic [CNT_W+4:0] count_ext;

  ierl_result_t res;
  ierl_result_t out_q;
  logic         out_valid;

  assign scan_last = (CNT_W'(scan_idx) + CNT_W'(1)) == valid_count;
  assign out_free  = !out_valid || rsp.ready;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = (valid_count == '0) ? ST_EVAL : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_EVAL;
      ST_EVAL: begin
        state_next = (q_mode == MODE_READ && rd_ok) ? ST_RDATA : ST_OUT;
      end
      ST_RDATA: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    req.ready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = scan_idx;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_SCAN: rd_en = 1'b1;
      ST_EVAL: begin
        rd_en   = (q_mode == MODE_READ) && rd_ok;
        rd_addr = slot_sel;
      end
      ST_OUT: out_load = out_free;
      default: ;
    endcase
  end

  // Decision taken once the scan is complete.
  always_comb begin
    first_slot  = (valid_count == FULL_CNT) ? write_pointer : '0;
    sum_pos     = (CMP_W + 1)'(first_slot) + (CMP_W + 1)'(q_pos);
    sum_wrap    = (sum_pos >= (CMP_W + 1)'(RING_DEPTH)) ?
                  sum_pos - (CMP_W + 1)'(RING_DEPTH) : sum_pos;
    slot_sel    = sum_wrap[IDX_W-1:0];
    rd_ok       = CMP_W'(q_pos) < CMP_W'(valid_count);
    do_append   = 1'b0;
    do_close    = 1'b0;
    ev_status   = STAT_READ_BAD;
    ev_any      = (open_cnt != 2'd0);
    case (q_mode)
      MODE_START: begin
        ev_any = 1'b1;
        if (found) begin
          ev_status = STAT_ALREADY_OPEN;
        end else begin
          ev_status = STAT_STARTED;
          do_append = 1'b1;
        end
      end
      MODE_END: begin
        if (found) begin
          ev_status = STAT_ENDED;
          do_close  = 1'b1;
          ev_any    = (open_cnt == 2'd2) || (q_ts == '0);
        end else begin
          ev_status = STAT_NONE_OPEN;
        end
      end
      MODE_POINT: begin
        ev_status = STAT_POINT;
        do_append = 1'b1;
        ev_any    = open_excl || (q_ts == '0);
      end
      default: begin
        ev_status = rd_ok ? STAT_READ_OK : STAT_READ_BAD;
      end
    endcase
    count_after = (do_append && valid_count != FULL_CNT) ? valid_count + CNT_W'(1) :
                  valid_count;
    count_ext   = {5'b0, count_after};
  end

  // Memory write ports.
  always_comb begin
    meta_we   = (state == ST_EVAL) && do_append;
    end_we    = (state == ST_EVAL) && (do_append || do_close);
    end_waddr = do_close ? match_idx : write_pointer;
    end_wdata = (q_mode == MODE_POINT || do_close) ? q_ts : '0;
  end

  // Record memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[write_pointer] <= '{reason: q_reason,
                                   detail: (q_mode == MODE_POINT) ? q_detail : 8'd0,
                                   start: q_ts};
    end
    if (rd_en) begin
      rd_meta <= meta_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (end_we) begin
      end_mem[end_waddr] <= end_wdata;
    end
    if (rd_en) begin
      rd_end <= end_mem[rd_addr];
    end
  end

  // State register and ring bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      valid_count   <= '0;
      write_pointer <= '0;
      newest_reason <= '0;
      pend          <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= (state == ST_SCAN);
      if (state == ST_EVAL && do_append) begin
        valid_count   <= count_after;
        write_pointer <= (write_pointer == PTR_WRAP) ? '0 : write_pointer + IDX_W'(1);
        newest_reason <= q_reason;
      end
    end
  end

  // Request capture and the scan over valid slots.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      q_mode    <= req.mode;
      q_reason  <= req.reason;
      q_detail  <= req.detail;
      q_ts      <= req.timestamp;
      q_pos     <= req.read_position;
      scan_idx  <= '0;
      found     <= 1'b0;
      match_idx <= '0;
      open_cnt  <= 2'd0;
      open_excl <= 1'b0;
    end else begin
      if (state == ST_SCAN) begin
        scan_idx <= scan_idx + IDX_W'(1);
        pend_idx <= scan_idx;
      end
      if (pend && rd_end == '0) begin
        if (open_cnt != 2'd2) begin
          open_cnt <= open_cnt + 2'd1;
        end
        if (!(valid_count == FULL_CNT && pend_idx == write_pointer)) begin
          open_excl <= 1'b1;
        end
        if (!found && rd_meta.reason == q_reason) begin
          found     <= 1'b1;
          match_idx <= pend_idx;
        end
      end
    end
  end

  // Result assembly.
  always_ff @(posedge clk) begin
    if (state == ST_EVAL) begin
      res.status        <= ev_status;
      res.entry_count   <= count_ext[4:0];
      res.any_open      <= ev_any;
      res.newest_reason <= do_append ? q_reason : newest_reason;
      res.entry_reason  <= '0;
      res.entry_detail  <= '0;
      res.entry_start   <= '0;
      res.entry_end     <= '0;
    end else if (state == ST_RDATA) begin
      res.entry_reason <= rd_meta.reason;
      res.entry_detail <= rd_meta.detail;
      res.entry_start  <= rd_meta.start;
      res.entry_end    <= rd_end;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_q.status;
  assign rsp.entry_count   = out_q.entry_count;
  assign rsp.any_open      = out_q.any_open;
  assign rsp.newest_reason = out_q.newest_reason;
  assign rsp.entry_reason  = out_q.entry_reason;
  assign rsp.entry_detail  = out_q.entry_detail;
  assign rsp.entry_start   = out_q.entry_start;
  assign rsp.entry_end     = out_q.entry_end;

  // The count never passes the ring depth and never falls.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_count <= FULL_CNT)
    else $error("entry count above ring depth");

  a_count_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> valid_count >= $past(valid_count))
    else $error("entry count decreased");

  // Until the ring is full, the write pointer follows the count.
  a_fill_ptr: assert property (@(posedge clk) disable iff (rst)
    valid_count != FULL_CNT |-> CNT_W'(write_pointer) == valid_count)
    else $error("write pointer out of step with entry count");

  // A pending scan read only exists right after a scan cycle.
  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == ST_SCAN || state == ST_DRAIN))
    else $error("scan read outside the scan");

  // Entry fields are only nonzero on a successful read.
  a_read_fields: assert property (@(posedge clk)
    rsp.valid && rsp.status != STAT_READ_OK |->
    rsp.entry_start == '0 && rsp.entry_end == '0 && rsp.entry_reason == '0)
    else $error("entry fields set on a result that is not a read");

endmodule

// File: test/interval_event_ring_log_tb.sv
// Self-checking testbench for the interval event ring log with a predicting scoreboard.
module interval_event_ring_log_tb;
  import ierl_pkg::*;

  localparam int LOG_DEPTH   = 20;
  localparam int RANDOM_REQS = 1700;
  localparam int CALM_REQS   = 200;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 40;
  localparam int PRINT_CAP   = 40;

  // Predicts every result of the ring log and checks the results that come back.
  class ring_log_tracker;
    logic [7:0]   kind_mem[LOG_DEPTH];
    logic [7:0]   detail_mem[LOG_DEPTH];
    logic [31:0]  start_mem[LOG_DEPTH];
    logic [31:0]  stop_mem[LOG_DEPTH];
    int unsigned  used;
    int unsigned  wr_ptr;
    int unsigned  mismatches;
    int unsigned  results_seen;
    ierl_result_t pending_results[$];

    function new();
      used         = 0;
      wr_ptr       = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // Lowest valid slot holding an open record of this kind, or -1.
    function int find_open(input logic [7:0] kind);
      for (int i = 0; i < used; i++) begin
        if (kind_mem[i] == kind && stop_mem[i] == 32'd0) return i;
      end
      return -1;
    endfunction

    // Writes a record at the write pointer, replacing the oldest one when full.
    function void append(input logic [7:0] kind, input logic [7:0] det,
                         input logic [31:0] t0, input logic [31:0] t1);
      kind_mem[wr_ptr]   = kind;
      detail_mem[wr_ptr] = det;
      start_mem[wr_ptr]  = t0;
      stop_mem[wr_ptr]   = t1;
      wr_ptr = (wr_ptr + 1) % LOG_DEPTH;
      if (used < LOG_DEPTH) used++;
    endfunction

    // Applies one accepted request to the log copy and queues its result.
    function void log_request(input logic [1:0] mode, input logic [7:0] kind,
                              input logic [7:0] det, input logic [31:0] ts,
                              input logic [4:0] pos);
      ierl_result_t want;
      int           hit;
      int unsigned  slot;
      want = '0;
      case (mode)
        MODE_START: begin
          if (find_open(kind) >= 0) begin
            want.status = STAT_ALREADY_OPEN;
          end else begin
            append(kind, 8'd0, ts, 32'd0);
            want.status = STAT_STARTED;
          end
        end
        MODE_END: begin
          hit = find_open(kind);
          if (hit >= 0) begin
            stop_mem[hit] = ts;
            want.status = STAT_ENDED;
          end else begin
            want.status = STAT_NONE_OPEN;
          end
        end
        MODE_POINT: begin
          append(kind, det, ts, ts);
          want.status = STAT_POINT;
        end
        default: begin
          if (pos < used) begin
            slot = (((used == LOG_DEPTH) ? wr_ptr : 0) + pos) % LOG_DEPTH;
            want.entry_reason = kind_mem[slot];
            want.entry_detail = detail_mem[slot];
            want.entry_start  = start_mem[slot];
            want.entry_end    = stop_mem[slot];
            want.status = STAT_READ_OK;
          end else begin
            want.status = STAT_READ_BAD;
          end
        end
      endcase
      want.entry_count = 5'(used);
      for (int i = 0; i < used; i++) begin
        if (stop_mem[i] == 32'd0) want.any_open = 1'b1;
      end
      if (used > 0) want.newest_reason = kind_mem[(wr_ptr + LOG_DEPTH - 1) % LOG_DEPTH];
      pending_results.push_back(want);
    endfunction

    task report_mismatch(input string msg);
      if (mismatches < PRINT_CAP) $display("mismatch at result %0d: %s", results_seen, msg);
      mismatches++;
    endtask

    task check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, want));
    endtask

    // Compares one result with the oldest prediction, field by field.
    task check_result(input ierl_result_t got);
      ierl_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("entry_count", 32'(got.entry_count), 32'(want.entry_count));
        check_field("any_open", 32'(got.any_open), 32'(want.any_open));
        check_field("newest_reason", 32'(got.newest_reason), 32'(want.newest_reason));
        check_field("entry_reason", 32'(got.entry_reason), 32'(want.entry_reason));
        check_field("entry_detail", 32'(got.entry_detail), 32'(want.entry_detail));
        check_field("entry_start", got.entry_start, want.entry_start);
        check_field("entry_end", got.entry_end, want.entry_end);
      end
      results_seen++;
    endtask
  endclass

  logic clk;
  logic rst;

  ierl_req_if req_ch();
  ierl_rsp_if rsp_ch();

  ring_log_tracker board;

  // Flags shared between the request driver and the result side.
  logic        hold_results;
  logic        quiet;
  int unsigned cycle_count;

  interval_event_ring_log #(
    .RING_DEPTH(LOG_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offers one request and returns at the edge where it is accepted.
  task automatic send_event(input logic [1:0] mode, input logic [7:0] kind,
                            input logic [7:0] det, input logic [31:0] ts,
                            input logic [4:0] pos);
    req_ch.valid         <= 1'b1;
    req_ch.mode          <= mode;
    req_ch.reason        <= kind;
    req_ch.detail        <= det;
    req_ch.timestamp     <= ts;
    req_ch.read_position <= pos;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    board.log_request(mode, kind, det, ts, pos);
  endtask

  task automatic idle_sender(input int unsigned cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops offering requests until every predicted result has come back.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending_results.size() != 0);
  endtask

  // Result ready: random stalls, one long hold-off, and none at the end.
  initial begin : result_ready_driver
    int unsigned held;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_results) begin
        rsp_ch.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_results = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // Sample every accepted result at the clock edge.
  always @(posedge clk) begin : result_monitor
    ierl_result_t seen;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      seen.status        = rsp_ch.status;
      seen.entry_count   = rsp_ch.entry_count;
      seen.any_open      = rsp_ch.any_open;
      seen.newest_reason = rsp_ch.newest_reason;
      seen.entry_reason  = rsp_ch.entry_reason;
      seen.entry_detail  = rsp_ch.entry_detail;
      seen.entry_start   = rsp_ch.entry_start;
      seen.entry_end     = rsp_ch.entry_end;
      board.check_result(seen);
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[interval_event_ring_log] ERROR");
    $finish;
  end

  // Request stimulus and end of run.
  initial begin : request_driver
    logic [7:0]  kinds[4];
    logic [31:0] now_s;
    logic [31:0] ts;
    logic [1:0]  mode;
    logic [7:0]  kind;
    logic [4:0]  pos;
    int unsigned pick;
    int unsigned idle_pct;

    board        = new();
    hold_results = 1'b0;
    quiet        = 1'b0;
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.mode          <= MODE_START;
    req_ch.reason        <= 8'd0;
    req_ch.detail        <= 8'd0;
    req_ch.timestamp     <= 32'd0;
    req_ch.read_position <= 5'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty log, duplicate starts, zero times and field extremes.
    send_event(MODE_READ, 8'd0, 8'd0, 32'd0, 5'd0);
    send_event(MODE_END, 8'd5, 8'd0, 32'd9, 5'd0);
    send_event(MODE_START, 8'd0, 8'hff, 32'd1, 5'd31);
    send_event(MODE_START, 8'd0, 8'd0, 32'd2, 5'd0);
    send_event(MODE_POINT, 8'hff, 8'hff, 32'hffff_ffff, 5'd0);
    send_event(MODE_START, 8'hff, 8'd0, 32'hffff_ffff, 5'd0);
    // An end at time zero leaves the interval open.
    send_event(MODE_END, 8'd0, 8'd0, 32'd0, 5'd0);
    send_event(MODE_END, 8'd0, 8'd0, 32'd100, 5'd0);
    // A point event at time zero counts as an open record.
    send_event(MODE_POINT, 8'd7, 8'd0, 32'd0, 5'd0);
    send_event(MODE_END, 8'd7, 8'd0, 32'd5, 5'd0);
    send_event(MODE_END, 8'hff, 8'd0, 32'hffff_ffff, 5'd0);
    send_event(MODE_START, 8'haa, 8'h55, 32'h5555_5555, 5'd0);
    send_event(MODE_READ, 8'd0, 8'd0, 32'd0, 5'd0);
    send_event(MODE_READ, 8'd0, 8'd0, 32'd0, 5'd1);
    send_event(MODE_READ, 8'd0, 8'd0, 32'd0, 5'd2);
    send_event(MODE_READ, 8'd0, 8'd0, 32'd0, 5'd3);
    send_event(MODE_READ, 8'd0, 8'd0, 32'd0, 5'd4);
    send_event(MODE_READ, 8'd0, 8'd0, 32'd0, 5'd5);
    send_event(MODE_READ, 8'd0, 8'd0, 32'd0, 5'd6);
    send_event(MODE_READ, 8'd0, 8'd0, 32'd0, 5'd19);
    send_event(MODE_READ, 8'd0, 8'd0, 32'd0, 5'd20);
    send_event(MODE_READ, 8'hff, 8'hff, 32'hffff_ffff, 5'd31);

    // Random part: mostly start/end/point/read traffic on a few kinds, some noise.
    now_s    = $urandom;
    idle_pct = 0;
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 128 == 0) begin
        foreach (kinds[k]) kinds[k] = 8'($urandom_range(0, 255));
      end
      if (i % 100 == 0) begin
        pick = $urandom_range(0, 2);
        idle_pct = (pick == 0) ? 0 : ((pick == 1) ? 15 : 50);
      end
      if (i == 400) hold_results = 1'b1;
      if (i == 900) wait_drained();
      if (i == RANDOM_REQS - CALM_REQS) quiet = 1'b1;

      now_s = now_s + 32'($urandom_range(1, 1000));
      pick  = $urandom_range(0, 99);
      ts    = (pick < 3) ? 32'd0 : ((pick < 8) ? 32'($urandom) : now_s);
      pick  = $urandom_range(0, 99);
      if (pick < 8) begin
        mode = 2'($urandom_range(0, 3));
        kind = 8'($urandom_range(0, 255));
        pos  = 5'($urandom_range(0, 31));
      end else begin
        pick = $urandom_range(0, 99);
        mode = (pick < 30) ? MODE_START : ((pick < 60) ? MODE_END :
               ((pick < 75) ? MODE_POINT : MODE_READ));
        kind = kinds[$urandom_range(0, 3)];
        pos  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, board.used));
      end

      if (!quiet && $urandom_range(0, 99) < idle_pct) idle_sender($urandom_range(1, 19));
      send_event(mode, kind, 8'($urandom_range(0, 255)), ts, pos);
    end

    // Let the last results come back, then allow the block to settle.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("[interval_event_ring_log] OK");
    end else begin
      $display("[interval_event_ring_log] ERROR");
    end
    $finish;
  end

endmodule
